FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define HRMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HRMP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/hrmp_pkg.sv
// Types and constants of the heart rate measurement parser.
package hrmp_pkg;

    // Command queue depth between front and back.
    localparam int unsigned HRMP_QUEUE_DEPTH = 4;

    // RR interval conversion: ms = (raw * 1000) >> 10.
    localparam int unsigned RR_SCALE  = 1000;
    localparam int unsigned RR_SHIFT  = 10;
    localparam int unsigned RR_RAW_W  = 16;
    localparam int unsigned RR_PROD_W = RR_RAW_W + RR_SHIFT;

    // Result kinds.
    localparam logic KIND_RR      = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Largest RR value in ms.
    localparam logic [15:0] RR_MS_MAX = 16'd63999;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       char_match;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [15:0] rr_ms;
        logic [15:0] hr_bpm;
        logic [15:0] energy;
        logic        contact_ok;
        logic        last;
    } t_out;

    // One queued command: an optional RR interval and an optional summary.
    typedef struct packed {
        logic                has_rr;
        logic [RR_RAW_W-1:0] rr_raw;
        logic                has_sum;
        logic [15:0]         hr_bpm;
        logic [15:0]         energy;
        logic                contact_ok;
    } t_cmd;

endpackage

FILE: sv/heart_rate_measurement_parser.sv
// Heart rate measurement parser: one payload byte per transaction in, RR
// intervals and a packet summary out. The input takes one byte per clock as
// long as the command queue (QUEUE_DEPTH entries) has room; the front parser
// updates its field state in the cycle a byte is accepted and needs no more
// than that. Bytes with char_match low are consumed and ignored. A byte that
// completes an RR interval, or carries the last-byte mark, queues one command;
// the back end turns it into one result, or two when the last byte also
// completes an RR interval (RR first, then the summary), so the output side
// sets the sustained rate: one result per clock while the receiver is ready.
// A result passes the queue write, the command register and the output
// register on its way out after its byte is accepted. RR
// intervals are converted from 1/1024 s units to ms as floor(raw*1000/1024)
// by one 16x10 constant multiply ahead of the output register. The summary
// carries the heart rate, the last energy value received (kept when a packet
// has none) and contact_ok, set when both sensor contact flag bits are set.
module heart_rate_measurement_parser
    import hrmp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = HRMP_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // byte transactions in
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    // result transactions out
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic q_full, q_push, q_valid, q_pop;
    t_cmd q_wr_cmd, q_rd_cmd;

    // parse state machine; pushes a command per byte that yields results
    hrmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_wr_cmd)
    );

    // decouples parsing from output back-pressure
    hrmp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wr_cmd),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_data      (q_rd_cmd)
    );

    // result formatting and the registered output
    hrmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_pop       (q_pop),
        .i_cmd       (q_rd_cmd),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (o_out_data)
    );

endmodule

FILE: sv/hrmp_front.sv
// Front end: accepts payload bytes, runs the field parser, issues commands.
module hrmp_front
    import hrmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_HR_LO,
        PH_HR_HI,
        PH_EN_LO,
        PH_EN_HI,
        PH_RR_LO,
        PH_RR_HI,
        PH_SKIP
    } t_phase;

    localparam int FLAG_HR16   = 0;
    localparam int FLAG_ENERGY = 3;
    localparam int FLAG_RR     = 4;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_flags, n_flags;
    logic [15:0] r_rate, n_rate;
    logic [15:0] r_energy, n_energy;
    logic [7:0]  r_low, n_low;
    logic        rr_hit;
    logic        take;

    function automatic t_phase after_energy(input logic [4:0] flags);
        return flags[FLAG_RR] ? PH_RR_LO : PH_SKIP;
    endfunction

    function automatic t_phase after_rate(input logic [4:0] flags);
        return flags[FLAG_ENERGY] ? PH_EN_LO : after_energy(flags);
    endfunction

    assign o_ready = !i_full;
    // foreign bytes are consumed but leave no trace
    assign take    = i_valid && o_ready && i_item.char_match;

    always_comb begin
        n_phase  = r_phase;
        n_flags  = r_flags;
        n_rate   = r_rate;
        n_energy = r_energy;
        n_low    = r_low;
        rr_hit   = 1'b0;
        unique case (r_phase)
            PH_FLAGS: begin
                n_flags = i_item.data_byte[4:0];
                n_phase = PH_HR_LO;
            end
            PH_HR_LO: begin
                if (r_flags[FLAG_HR16]) begin
                    n_low   = i_item.data_byte;
                    n_phase = PH_HR_HI;
                end else begin
                    n_rate  = {8'h00, i_item.data_byte};
                    n_phase = after_rate(r_flags);
                end
            end
            PH_HR_HI: begin
                n_rate  = {i_item.data_byte, r_low};
                n_phase = after_rate(r_flags);
            end
            PH_EN_LO: begin
                n_low   = i_item.data_byte;
                n_phase = PH_EN_HI;
            end
            PH_EN_HI: begin
                n_energy = {i_item.data_byte, r_low};
                n_phase  = after_energy(r_flags);
            end
            PH_RR_LO: begin
                n_low   = i_item.data_byte;
                n_phase = PH_RR_HI;
            end
            PH_RR_HI: begin
                rr_hit  = 1'b1;
                n_phase = PH_RR_LO;
            end
            PH_SKIP: begin
                n_phase = PH_SKIP;
            end
        endcase
        if (i_item.last_byte) begin
            n_phase = PH_FLAGS;
        end
    end

    assign o_push            = take && (rr_hit || i_item.last_byte);
    assign o_cmd.has_rr      = rr_hit;
    assign o_cmd.rr_raw      = {i_item.data_byte, r_low};
    assign o_cmd.has_sum     = i_item.last_byte;
    assign o_cmd.hr_bpm      = n_rate;
    assign o_cmd.energy      = n_energy;
    assign o_cmd.contact_ok  = &n_flags[2:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FLAGS;
            r_flags  <= '0;
            r_rate   <= '0;
            r_energy <= '0;
            r_low    <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_flags  <= n_flags;
            r_rate   <= n_rate;
            r_energy <= n_energy;
            r_low    <= n_low;
        end
    end

endmodule

FILE: sv/hrmp_queue.sv
// Small command queue between front and back.
module hrmp_queue
    import hrmp_pkg::*;
#(
    parameter int unsigned DEPTH = HRMP_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/hrmp_back.sv
// Back end: expands commands into results, converts RR to ms, drives output.
module hrmp_back
    import hrmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_pop,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_res
);

    t_cmd                 r_cmd;
    logic                 r_cmd_valid;
    t_out                 r_out, n_out;
    logic                 r_out_valid;
    logic                 load, emit, cmd_done;
    logic [RR_PROD_W-1:0] prod;

    assign load     = !r_out_valid || i_ready;
    assign emit     = r_cmd_valid && load;
    // a command with both parts takes two emits, RR first
    assign cmd_done = emit && !(r_cmd.has_rr && r_cmd.has_sum);
    assign o_pop    = i_cmd_valid && (!r_cmd_valid || cmd_done);

    assign prod = RR_PROD_W'(RR_PROD_W'(r_cmd.rr_raw) * RR_PROD_W'(RR_SCALE));

    always_comb begin
        if (r_cmd.has_rr) begin
            n_out.kind       = KIND_RR;
            n_out.rr_ms      = prod[RR_PROD_W-1:RR_SHIFT];
            n_out.hr_bpm     = '0;
            n_out.energy     = '0;
            n_out.contact_ok = 1'b0;
            n_out.last       = !r_cmd.has_sum;
        end else begin
            n_out.kind       = KIND_SUMMARY;
            n_out.rr_ms      = '0;
            n_out.hr_bpm     = r_cmd.hr_bpm;
            n_out.energy     = r_cmd.energy;
            n_out.contact_ok = r_cmd.contact_ok;
            n_out.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd_valid <= 1'b1;
            end else if (cmd_done) begin
                r_cmd_valid <= 1'b0;
            end
            if (load) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end else if (emit) begin
            r_cmd.has_rr <= 1'b0;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

FILE: sv/hrmp_checker.sv
// Port-level checks of the heart rate measurement parser, bound to the top.
`include "assert_macros.svh"

module hrmp_checker
    import hrmp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    `HRMP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `HRMP_ASSERT_RST(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid right after reset")
    `HRMP_ASSERT(a_rr_clean, i_clk, i_rst_n, o_out_valid && o_out_data.kind == KIND_RR |-> o_out_data.hr_bpm == '0 && o_out_data.energy == '0 && !o_out_data.contact_ok && o_out_data.rr_ms <= RR_MS_MAX, "bad RR result fields")
    `HRMP_ASSERT(a_sum_last, i_clk, i_rst_n, o_out_valid && o_out_data.kind == KIND_SUMMARY |-> o_out_data.last && o_out_data.rr_ms == '0, "summary not marked last")

endmodule

bind heart_rate_measurement_parser hrmp_checker u_hrmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/sv/heart_rate_measurement_parser_tb.sv
// Self-checking testbench for the heart rate measurement parser.
`timescale 1ns / 100ps

module heart_rate_measurement_parser_tb;
    import hrmp_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT  = 400000;  // generous limit for the whole run
    localparam int DRAIN_CYCLES = 16;      // idle margin after the last result
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the command queue
    localparam int RANDOM_ITEMS = 640;
    localparam int MAX_REPORTS  = 10;

    // Flags byte layout
    localparam int FLG_RATE16 = 0;
    localparam int FLG_ENERGY = 3;
    localparam int FLG_RR     = 4;

    // Parse position of the shadow parser
    typedef enum logic [2:0] {
        AT_FLAGS,
        AT_RATE_LO,
        AT_RATE_HI,
        AT_ENERGY_LO,
        AT_ENERGY_HI,
        AT_RR_LO,
        AT_RR_HI,
        AT_SURPLUS
    } t_rx_pos;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Shadow parser state
    t_rx_pos     pos_q     = AT_FLAGS;
    logic [4:0]  flags_q   = '0;
    logic [15:0] rate_q    = '0;
    logic [15:0] energy_q  = '0;
    logic [7:0]  lo_byte_q = '0;

    // Results predicted but not yet seen at the output
    t_out results_due[$];

    // Bytes of the packet being built by the random test
    logic [7:0] pkt_bytes[$];

    int  fail_count    = 0;
    int  items_sent    = 0;  // char_match bytes only; foreign bytes don't count
    int  cycle_count   = 0;
    bit  in_gaps_on    = 1'b0;
    bit  out_stalls_on = 1'b0;
    bit  hold_request  = 1'b0;

    heart_rate_measurement_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow parser: where the next byte goes once the rate or energy is done
    // ------------------------------------------------------------------
    function automatic t_rx_pos pos_after_energy();
        return flags_q[FLG_RR] ? AT_RR_LO : AT_SURPLUS;
    endfunction

    function automatic t_rx_pos pos_after_rate();
        return flags_q[FLG_ENERGY] ? AT_ENERGY_LO : pos_after_energy();
    endfunction

    // Advance the shadow parser by one accepted byte, queue what it emits.
    function automatic void predict_byte(input t_in item);
        t_out        res;
        logic [15:0] raw;
        logic [25:0] prod;
        logic        rr_done;
        logic [15:0] rr_val;

        if (!item.char_match)
            return;  // foreign byte: no state change, last mark ignored

        rr_done = 1'b0;
        rr_val  = '0;
        case (pos_q)
            AT_FLAGS: begin
                flags_q = item.data_byte[4:0];
                pos_q   = AT_RATE_LO;
            end
            AT_RATE_LO: begin
                if (flags_q[FLG_RATE16]) begin
                    lo_byte_q = item.data_byte;
                    pos_q     = AT_RATE_HI;
                end else begin
                    rate_q = {8'h00, item.data_byte};  // one-byte rate clears high byte
                    pos_q  = pos_after_rate();
                end
            end
            AT_RATE_HI: begin
                rate_q = {item.data_byte, lo_byte_q};
                pos_q  = pos_after_rate();
            end
            AT_ENERGY_LO: begin
                lo_byte_q = item.data_byte;
                pos_q     = AT_ENERGY_HI;
            end
            AT_ENERGY_HI: begin
                energy_q = {item.data_byte, lo_byte_q};
                pos_q    = pos_after_energy();
            end
            AT_RR_LO: begin
                lo_byte_q = item.data_byte;
                pos_q     = AT_RR_HI;
            end
            AT_RR_HI: begin
                // 1/1024 s -> ms, floor
                raw     = {item.data_byte, lo_byte_q};
                prod    = raw * 26'd1000;
                rr_val  = prod[25:10];
                rr_done = 1'b1;
                pos_q   = AT_RR_LO;
            end
            default: ;  // surplus bytes wait for the last mark
        endcase

        if (rr_done) begin
            res            = '0;
            res.kind       = KIND_RR;
            res.rr_ms      = rr_val;
            res.last       = !item.last_byte;  // summary follows when last
            results_due    = {results_due, res};
        end
        if (item.last_byte) begin
            res            = '0;
            res.kind       = KIND_SUMMARY;
            res.hr_bpm     = rate_q;
            res.energy     = energy_q;
            res.contact_ok = (flags_q[2:1] == 2'b11);
            res.last       = 1'b1;
            results_due    = {results_due, res};
            pos_q          = AT_FLAGS;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on each input transaction, check each output one.
    // Both sides sample pre-edge values, so order within the step is moot.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out want;
        t_out got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_byte(i_in_data);
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: kind=%0d rr=%0d hr=%0d en=%0d",
                                 got.kind, got.rr_ms, got.hr_bpm, got.energy,
                                 " c=%0d last=%0d", got.contact_ok, got.last);
                end else begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.rr_ms !== want.rr_ms ||
                        got.hr_bpm !== want.hr_bpm || got.energy !== want.energy ||
                        got.contact_ok !== want.contact_ok || got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at cycle %0d:", cycle_count,
                                     " exp kind=%0d rr=%0d hr=%0d en=%0d c=%0d last=%0d",
                                     want.kind, want.rr_ms, want.hr_bpm,
                                     want.energy, want.contact_ok, want.last,
                                     " | got kind=%0d rr=%0d hr=%0d en=%0d c=%0d last=%0d",
                                     got.kind, got.rr_ms, got.hr_bpm, got.energy,
                                     got.contact_ok, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, or a long hold-off on request.
    // One NBA to i_out_ready per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : out_ready_drive
        int hold_left;
        int stall_left;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_stalls_on && stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(0, 14));
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: one byte transaction. Valid stays up between back-to-back
    // transactions; it only drops for an idle burst or a pause.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input logic last_mark,
                             input logic match);
        t_in item;
        item.data_byte  = data;
        item.last_byte  = last_mark;
        item.char_match = match;
        if (in_gaps_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (match)
            items_sent++;
    endtask

    // Sender pause: stop offering until every predicted result came out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);  // lets the monitor book the last transaction
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Byte with extra weight on the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed packet with random content; sometimes an odd RR byte,
    // surplus bytes, a cut-short packet, or foreign bytes mixed in.
    task automatic send_random_packet();
        logic [7:0] flags;
        int         n_rr;
        int         cut;
        pkt_bytes.delete();
        flags = 8'($urandom_range(0, 255));
        pkt_bytes = {pkt_bytes, flags};
        pkt_bytes = {pkt_bytes, pick_byte()};
        if (flags[FLG_RATE16])
            pkt_bytes = {pkt_bytes, pick_byte()};
        if (flags[FLG_ENERGY])
            repeat (2) pkt_bytes = {pkt_bytes, pick_byte()};
        if (flags[FLG_RR]) begin
            n_rr = int'($urandom_range(0, 3));
            repeat (2 * n_rr) pkt_bytes = {pkt_bytes, pick_byte()};
            if ($urandom_range(0, 5) == 0)
                pkt_bytes = {pkt_bytes, pick_byte()};  // odd trailing byte
        end else if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) pkt_bytes = {pkt_bytes, pick_byte()};
        end
        cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, pkt_bytes.size()))
                                          : pkt_bytes.size();
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            send_byte(pkt_bytes[i], i == cut - 1, 1'b1);
        end
    endtask

    // Unstructured bytes: random last marks, random char_match
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked packets: field extremes and each corner of the format.
    task automatic test_directed();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        // all-zero packet, one-byte rate
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        // every flag set, all-ones fields; last byte also completes an RR
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // contact only; one-byte rate drops the old high byte, energy kept
        send_byte(8'h06, 1'b0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);
        // RR packet with a foreign byte (last mark ignored), RR of 1 s and 0,
        // then an odd byte on the last mark
        send_byte(8'h10, 1'b0, 1'b1);
        send_byte(8'hAA, 1'b1, 1'b0);
        send_byte(8'h48, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h04, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h55, 1'b1, 1'b1);
        // 16-bit rate cut short: old rate reported
        send_byte(8'h09, 1'b0, 1'b1);
        send_byte(8'h34, 1'b1, 1'b1);
        // surplus bytes without RR
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        // flags byte alone, one contact bit only
        send_byte(8'h02, 1'b1, 1'b1);
    endtask

    // Receiver holds off while RR-heavy packets keep coming, so the
    // command queue fills and the input side has to stall.
    task automatic test_backpressure();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        hold_request  = 1'b1;
        repeat (10) begin
            send_byte(8'h16, 1'b0, 1'b1);
            send_byte(pick_byte(), 1'b0, 1'b1);
            repeat (5) send_byte(pick_byte(), 1'b0, 1'b1);
            send_byte(pick_byte(), 1'b1, 1'b1);
        end
    endtask

    // Mostly well-formed random packets, some noise; a full pause halfway
    // and no idling at all in the last quarter.
    task automatic test_random();
        int  start;
        bit  paused;
        start         = items_sent;
        paused        = 1'b0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        while (items_sent < start + RANDOM_ITEMS) begin
            if (!paused && items_sent >= start + RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            if (items_sent >= start + (3 * RANDOM_ITEMS) / 4) begin
                in_gaps_on    = 1'b0;
                out_stalls_on = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_random_packet();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random();
        wait_drained();

        if (fail_count == 0 && results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
